// ===== sv/trss_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// trss_pkg
// Shared constants, types and fixed-point helpers of the temperature
// relaxation and sponge source core.
// ----------------------------------------------------------------------------
package trss_pkg;

  localparam int PROFILE_DEPTH = 16;
  localparam int FRAC_BITS     = 16;
  localparam int IDX_W         = $clog2(PROFILE_DEPTH);
  localparam int N_W           = $clog2(PROFILE_DEPTH + 1);
  localparam int VAL_W         = 32;
  localparam int DIV_STEP      = 2;
  localparam int DIV_STG       = VAL_W / DIV_STEP;
  localparam int INTERP_LAT    = DIV_STG + 3;
  localparam int DAMP_LAT      = 4;
  localparam int CARRY_N       = INTERP_LAT + 1;
  localparam int TERM_W        = 67 - FRAC_BITS;
  localparam int SUM_W         = TERM_W + 2;

  localparam logic OP_LOAD = 1'b0;
  localparam logic OP_CELL = 1'b1;

  localparam logic [2:0] REG_START = 3'd0;
  localparam logic [2:0] REG_INVTS = 3'd1;
  localparam logic [2:0] REG_GAIN  = 3'd2;
  localparam logic [2:0] REG_WEST  = 3'd3;
  localparam logic [2:0] REG_EAST  = 3'd4;
  localparam logic [2:0] REG_SOUTH = 3'd5;
  localparam logic [2:0] REG_NORTH = 3'd6;
  localparam logic [2:0] REG_COUNT = 3'd7;

  typedef struct packed {
    logic signed [31:0] start;
    logic [30:0]        inv_ts;
    logic [63:0]        gain;
    logic [63:0]        west;
    logic [63:0]        east;
    logic [63:0]        south;
    logic [63:0]        north;
    logic [4:0]         count;
  } cfg_t;

  typedef struct packed {
    logic               direct;
    logic signed [31:0] dval;
    logic signed [31:0] h0;
    logic signed [31:0] h1;
    logic signed [31:0] v0;
    logic signed [31:0] v1;
    logic signed [32:0] z;
  } seg_t;

  typedef struct packed {
    logic               rel;
    logic               npos;
    logic signed [31:0] temp;
    logic signed [31:0] src;
    logic [31:0]        s;
  } carry_t;

  function automatic logic [31:0] sat_u32(input logic [63:0] p);
    logic [63:0] sh;
    sh = p >> FRAC_BITS;
    if (|sh[63:32]) sat_u32 = '1;
    else sat_u32 = sh[31:0];
  endfunction

  function automatic logic signed [TERM_W-1:0] smul(input logic signed [33:0] a,
                                                     input logic [31:0] b);
    logic              neg;
    logic [33:0]       mag;
    logic [65:0]       prod;
    logic [TERM_W-1:0] sh;
    neg  = a[33];
    mag  = neg ? 34'(-a) : 34'(a);
    prod = 66'(mag) * 66'(b);
    sh   = TERM_W'(prod >> FRAC_BITS);
    smul = neg ? -$signed(sh) : $signed(sh);
  endfunction

  function automatic logic signed [31:0] sat_s32(input logic signed [SUM_W-1:0] v);
    if (v[SUM_W-1] && !(&v[SUM_W-2:31])) sat_s32 = 32'sh8000_0000;
    else if (!v[SUM_W-1] && (|v[SUM_W-2:31])) sat_s32 = 32'sh7FFF_FFFF;
    else sat_s32 = v[31:0];
  endfunction

endpackage

// ===== sv/trss_table.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// trss_table
// Profile store with parallel segment search for two heights per item.
// ----------------------------------------------------------------------------
module trss_table import trss_pkg::*; (
  input  logic                   clk_i,
  input  logic                   en_i,
  input  logic                   wr_i,
  input  logic [IDX_W-1:0]       wr_idx_i,
  input  logic signed [31:0]     wr_h_i,
  input  logic signed [31:0]     wr_v_i,
  input  logic [N_W-1:0]         n_i,
  input  logic signed [32:0]     za_i,
  input  logic signed [32:0]     zc_i,
  output seg_t                   seg_a_o,
  output seg_t                   seg_c_o
);

  logic signed [31:0] h_q [PROFILE_DEPTH];
  logic signed [31:0] v_q [PROFILE_DEPTH];
  seg_t seg_a_q, seg_c_q;
  seg_t seg_a, seg_c;

  function automatic seg_t lookup(input logic signed [32:0] z);
    logic [IDX_W-1:0] last, j, jm;
    logic             below, above;
    seg_t             s;
    last  = IDX_W'(n_i - 1'b1);
    below = z <= h_q[0];
    above = z >= h_q[last];
    j     = last;
    for (int k = PROFILE_DEPTH - 1; k >= 1; k--) begin
      if (k < int'(n_i) - 1 && h_q[k] > z) j = IDX_W'(k);
    end
    jm       = j - 1'b1;
    s.direct = below | above;
    s.dval   = below ? v_q[0] : v_q[last];
    s.h0     = h_q[jm];
    s.h1     = h_q[j];
    s.v0     = v_q[jm];
    s.v1     = v_q[j];
    s.z      = z;
    return s;
  endfunction

  always_ff @(posedge clk_i) begin
    if (wr_i) begin
      h_q[wr_idx_i] <= wr_h_i;
      v_q[wr_idx_i] <= wr_v_i;
    end
  end

  always_comb begin
    seg_a = lookup(za_i);
    seg_c = lookup(zc_i);
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      seg_a_q <= seg_a;
      seg_c_q <= seg_c;
    end
  end

  assign seg_a_o = seg_a_q;
  assign seg_c_o = seg_c_q;

endmodule

// ===== sv/trss_interp.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// trss_interp
// Pipelined linear interpolation on one profile segment, with a radix-4
// long division stage chain.
// ----------------------------------------------------------------------------
module trss_interp import trss_pkg::*; (
  input  logic               clk_i,
  input  logic               en_i,
  input  seg_t               seg_i,
  output logic signed [31:0] ref_o
);

  logic signed [32:0] dv;
  logic [33:0]        dz_w;
  logic [32:0]        dh_w, mag_w;

  logic               s1_direct_q, s1_neg_q;
  logic signed [31:0] s1_dval_q, s1_v0_q;
  logic [32:0]        s1_dz_q, s1_dh_q;
  logic [31:0]        s1_mag_q;

  logic               s2_direct_q, s2_neg_q;
  logic signed [31:0] s2_dval_q, s2_v0_q;
  logic [32:0]        s2_dh_q;
  logic [64:0]        s2_prod_q;

  logic [32:0]        rem_q  [DIV_STG];
  logic [31:0]        lo_q   [DIV_STG];
  logic [31:0]        quo_q  [DIV_STG];
  logic [32:0]        dh_q   [DIV_STG];
  logic               dir_q  [DIV_STG];
  logic               neg_q  [DIV_STG];
  logic signed [31:0] dval_q [DIV_STG];
  logic signed [31:0] v0_q   [DIV_STG];

  logic [32:0]        rem_d  [DIV_STG];
  logic [31:0]        lo_d   [DIV_STG];
  logic [31:0]        quo_d  [DIV_STG];

  logic signed [31:0] ref_q;

  always_comb begin
    dv    = 33'(seg_i.v1) - 33'(seg_i.v0);
    dz_w  = 34'(seg_i.z) - 34'(seg_i.h0);
    dh_w  = 33'(seg_i.h1) - 33'(seg_i.h0);
    mag_w = dv[32] ? 33'(-dv) : 33'(dv);
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      s1_direct_q <= seg_i.direct;
      s1_neg_q    <= dv[32];
      s1_dval_q   <= seg_i.dval;
      s1_v0_q     <= seg_i.v0;
      s1_dz_q     <= dz_w[32:0];
      s1_dh_q     <= dh_w;
      s1_mag_q    <= mag_w[31:0];

      s2_direct_q <= s1_direct_q;
      s2_neg_q    <= s1_neg_q;
      s2_dval_q   <= s1_dval_q;
      s2_v0_q     <= s1_v0_q;
      s2_dh_q     <= s1_dh_q;
      s2_prod_q   <= 65'(s1_mag_q) * 65'(s1_dz_q);
    end
  end

  // two quotient bits per stage
  always_comb begin
    logic [33:0] t;
    logic [32:0] r, d;
    logic [31:0] lo, qq;
    for (int g = 0; g < DIV_STG; g++) begin
      if (g == 0) begin
        r  = s2_prod_q[64:32];
        lo = s2_prod_q[31:0];
        qq = '0;
        d  = s2_dh_q;
      end else begin
        r  = rem_q[g-1];
        lo = lo_q[g-1];
        qq = quo_q[g-1];
        d  = dh_q[g-1];
      end
      for (int b = 0; b < DIV_STEP; b++) begin
        t  = {r, lo[31]};
        lo = {lo[30:0], 1'b0};
        if (t >= {1'b0, d}) begin
          r  = 33'(t - {1'b0, d});
          qq = {qq[30:0], 1'b1};
        end else begin
          r  = t[32:0];
          qq = {qq[30:0], 1'b0};
        end
      end
      rem_d[g] = r;
      lo_d[g]  = lo;
      quo_d[g] = qq;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int g = 0; g < DIV_STG; g++) begin
        rem_q[g] <= rem_d[g];
        lo_q[g]  <= lo_d[g];
        quo_q[g] <= quo_d[g];
        if (g == 0) begin
          dh_q[g]   <= s2_dh_q;
          dir_q[g]  <= s2_direct_q;
          neg_q[g]  <= s2_neg_q;
          dval_q[g] <= s2_dval_q;
          v0_q[g]   <= s2_v0_q;
        end else begin
          dh_q[g]   <= dh_q[g-1];
          dir_q[g]  <= dir_q[g-1];
          neg_q[g]  <= neg_q[g-1];
          dval_q[g] <= dval_q[g-1];
          v0_q[g]   <= v0_q[g-1];
        end
      end
      if (dir_q[DIV_STG-1]) ref_q <= dval_q[DIV_STG-1];
      else if (neg_q[DIV_STG-1]) ref_q <= v0_q[DIV_STG-1] - quo_q[DIV_STG-1];
      else ref_q <= v0_q[DIV_STG-1] + quo_q[DIV_STG-1];
    end
  end

  assign ref_o = ref_q;

endmodule

// ===== sv/trss_damp.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// trss_damp
// Quadratic sponge damping of one side, four register stages.
// ----------------------------------------------------------------------------
module trss_damp import trss_pkg::*; (
  input  logic               clk_i,
  input  logic               en_i,
  input  logic signed [31:0] coord_i,
  input  logic [63:0]        side_i,
  input  logic               rising_i,
  input  logic [31:0]        strength_i,
  output logic [31:0]        damp_o
);

  logic signed [32:0] d;
  logic               act;
  logic [31:0]        d_q, inv_q, xi_q, sq_q, dmp_q;

  always_comb begin
    if (rising_i) d = 33'(coord_i) - 33'($signed(side_i[63:32]));
    else d = 33'($signed(side_i[63:32])) - 33'(coord_i);
    act = (side_i[31:0] != '0) && !d[32] && (d != '0);
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      d_q   <= act ? d[31:0] : '0;
      inv_q <= side_i[31:0];
      xi_q  <= sat_u32(64'(d_q) * 64'(inv_q));
      sq_q  <= sat_u32(64'(xi_q) * 64'(xi_q));
      dmp_q <= sat_u32(64'(sq_q) * 64'(strength_i));
    end
  end

  assign damp_o = dmp_q;

endmodule

// ===== sv/temperature_relax_sponge_source_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// temperature_relax_sponge_source_core
// Temperature source term with profile relaxation and horizontal sponge.
// ----------------------------------------------------------------------------
// Usage:
//   The input channel (in_valid_i/in_ready_o) carries load items, which
//   write one profile entry and give no result, and cell items, which give
//   one source_out_o item on the output channel (out_valid_o/out_ready_i).
//   Registers are written over the APB-style port at byte address 8*index;
//   the user must write them only while the core is idle, which the core
//   does not enforce; pready is always high. A cell item passes the input
//   register, the table lookup, the two interpolation pipelines, whose long
//   division yields two quotient bits per stage, and two final-term stages
//   into the output register. Throughput: one item per cycle while the
//   output is not stalled; loads and cells may be interleaved, a load takes
//   effect for every cell accepted after it. Reset clears all registers and
//   pipeline valid bits; profile entries are undefined until loaded. When
//   the receiver stalls the whole pipeline holds and in_ready_o drops; the
//   input is ready again as soon as the output item is taken.
// ----------------------------------------------------------------------------
module temperature_relax_sponge_source_core import trss_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic               operation_i,
  input  logic [3:0]         entry_index_i,
  input  logic signed [31:0] entry_height_i,
  input  logic signed [31:0] entry_value_i,
  input  logic signed [31:0] cell_x_i,
  input  logic signed [31:0] cell_y_i,
  input  logic signed [31:0] cell_z_i,
  input  logic [30:0]        half_cell_height_i,
  input  logic signed [31:0] terrain_height_i,
  input  logic               blanked_i,
  input  logic signed [31:0] temperature_i,
  input  logic signed [31:0] source_in_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic signed [31:0] source_out_o,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [5:0]         paddr,
  input  logic [63:0]        pwdata,
  output logic [63:0]        prdata,
  output logic               pready
);

  cfg_t               cfg_q;
  logic [2:0]         reg_idx;
  logic [N_W-1:0]     n_eff;
  logic               adv;

  logic               p1_vld_q, p1_op_q, p1_blanked_q;
  logic [3:0]         p1_idx_q;
  logic signed [31:0] p1_eh_q, p1_ev_q, p1_cx_q, p1_cy_q, p1_cz_q, p1_temp_q, p1_src_q;
  logic signed [32:0] p1_zadj_q, z_raw, z_adj;

  seg_t               seg_a, seg_c;
  logic               tbl_wr;
  logic signed [31:0] ref_z, ref_c;

  logic [31:0]        dmp_w, dmp_e, dmp_s, dmp_n;
  logic [33:0]        s_wide;
  logic [31:0]        s_sum;

  carry_t             c_in;
  carry_t             c_mid;
  carry_t             c_q [CARRY_N];
  logic [CARRY_N-1:0] vld_q;

  logic               f1_vld_q, f2_vld_q, out_valid_q;
  logic signed [TERM_W-1:0] f1_relax_q, f2_relax_q, f2_spg_q;
  logic signed [31:0] f1_tgt_q, f1_temp_q, f1_src_q, f2_src_q, out_q;
  logic [31:0]        f1_s_q;
  logic signed [31:0] ref_sel, ref2_sel;
  logic signed [TERM_W-1:0] relax_w, tgt_w, spg_w;
  logic signed [SUM_W-1:0]  total;

  // configuration port
  assign pready  = 1'b1;
  assign reg_idx = paddr[5:3];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '0;
    end else if (psel && penable && pwrite) begin
      unique case (reg_idx)
        REG_START: cfg_q.start  <= $signed(pwdata[31:0]);
        REG_INVTS: cfg_q.inv_ts <= pwdata[30:0];
        REG_GAIN:  cfg_q.gain   <= pwdata;
        REG_WEST:  cfg_q.west   <= pwdata;
        REG_EAST:  cfg_q.east   <= pwdata;
        REG_SOUTH: cfg_q.south  <= pwdata;
        REG_NORTH: cfg_q.north  <= pwdata;
        REG_COUNT: cfg_q.count  <= pwdata[4:0];
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      REG_START: prdata = {32'b0, cfg_q.start};
      REG_INVTS: prdata = {33'b0, cfg_q.inv_ts};
      REG_GAIN:  prdata = cfg_q.gain;
      REG_WEST:  prdata = cfg_q.west;
      REG_EAST:  prdata = cfg_q.east;
      REG_SOUTH: prdata = cfg_q.south;
      REG_NORTH: prdata = cfg_q.north;
      REG_COUNT: prdata = {59'b0, cfg_q.count};
    endcase
  end

  always_comb begin
    if (int'(cfg_q.count) > PROFILE_DEPTH) n_eff = N_W'(PROFILE_DEPTH);
    else n_eff = N_W'(cfg_q.count);
  end

  // pipeline control
  assign adv        = !out_valid_q || out_ready_i;
  assign in_ready_o = adv;

  // stage 1: terrain-adjusted height
  always_comb begin
    z_raw = 33'(cell_z_i) - 33'(terrain_height_i);
    z_adj = (z_raw < $signed({2'b0, half_cell_height_i})) ?
            $signed({2'b0, half_cell_height_i}) : z_raw;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) p1_vld_q <= 1'b0;
    else if (adv) p1_vld_q <= in_valid_i;
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      p1_op_q      <= operation_i;
      p1_idx_q     <= entry_index_i;
      p1_eh_q      <= entry_height_i;
      p1_ev_q      <= entry_value_i;
      p1_cx_q      <= cell_x_i;
      p1_cy_q      <= cell_y_i;
      p1_cz_q      <= cell_z_i;
      p1_zadj_q    <= z_adj;
      p1_blanked_q <= blanked_i;
      p1_temp_q    <= temperature_i;
      p1_src_q     <= source_in_i;
    end
  end

  // profile table and interpolation
  assign tbl_wr = adv && p1_vld_q && (p1_op_q == OP_LOAD) &&
                  (int'(p1_idx_q) < PROFILE_DEPTH);

  trss_table u_table (
    .clk_i    (clk_i),
    .en_i     (adv),
    .wr_i     (tbl_wr),
    .wr_idx_i (IDX_W'(p1_idx_q)),
    .wr_h_i   (p1_eh_q),
    .wr_v_i   (p1_ev_q),
    .n_i      (n_eff),
    .za_i     (p1_zadj_q),
    .zc_i     (33'(p1_cz_q)),
    .seg_a_o  (seg_a),
    .seg_c_o  (seg_c)
  );

  trss_interp u_interp_z (
    .clk_i (clk_i),
    .en_i  (adv),
    .seg_i (seg_a),
    .ref_o (ref_z)
  );

  trss_interp u_interp_c (
    .clk_i (clk_i),
    .en_i  (adv),
    .seg_i (seg_c),
    .ref_o (ref_c)
  );

  // sponge sides
  trss_damp u_damp_w (
    .clk_i (clk_i), .en_i (adv), .coord_i (p1_cx_q), .side_i (cfg_q.west),
    .rising_i (1'b0), .strength_i (cfg_q.gain[63:32]), .damp_o (dmp_w)
  );

  trss_damp u_damp_e (
    .clk_i (clk_i), .en_i (adv), .coord_i (p1_cx_q), .side_i (cfg_q.east),
    .rising_i (1'b1), .strength_i (cfg_q.gain[63:32]), .damp_o (dmp_e)
  );

  trss_damp u_damp_s (
    .clk_i (clk_i), .en_i (adv), .coord_i (p1_cy_q), .side_i (cfg_q.south),
    .rising_i (1'b0), .strength_i (cfg_q.gain[63:32]), .damp_o (dmp_s)
  );

  trss_damp u_damp_n (
    .clk_i (clk_i), .en_i (adv), .coord_i (p1_cy_q), .side_i (cfg_q.north),
    .rising_i (1'b1), .strength_i (cfg_q.gain[63:32]), .damp_o (dmp_n)
  );

  always_comb begin
    s_wide = 34'(dmp_w) + 34'(dmp_e) + 34'(dmp_s) + 34'(dmp_n);
    s_sum  = (|s_wide[33:32]) ? '1 : s_wide[31:0];
  end

  // item data travelling beside the interpolators
  always_comb begin
    c_in.rel  = !p1_blanked_q && (p1_zadj_q > 33'(cfg_q.start)) && (n_eff != '0);
    c_in.npos = (n_eff != '0);
    c_in.temp = p1_temp_q;
    c_in.src  = p1_src_q;
    c_in.s    = '0;
  end

  always_comb begin
    c_mid   = c_q[DAMP_LAT-1];
    c_mid.s = s_sum;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) vld_q <= '0;
    else if (adv) vld_q <= {vld_q[CARRY_N-2:0], p1_vld_q && (p1_op_q == OP_CELL)};
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      c_q[0] <= c_in;
      for (int k = 1; k < CARRY_N; k++) begin
        if (k == DAMP_LAT) c_q[k] <= c_mid;
        else c_q[k] <= c_q[k-1];
      end
    end
  end

  // final terms
  always_comb begin
    ref_sel  = c_q[CARRY_N-1].rel  ? ref_z : c_q[CARRY_N-1].temp;
    ref2_sel = c_q[CARRY_N-1].npos ? ref_c : c_q[CARRY_N-1].temp;
    relax_w  = smul(34'(c_q[CARRY_N-1].temp) - 34'(ref_sel), {1'b0, cfg_q.inv_ts});
    tgt_w    = smul(34'(ref2_sel), cfg_q.gain[31:0]);
    spg_w    = smul(34'(f1_temp_q) - 34'(f1_tgt_q), f1_s_q);
    total    = SUM_W'(f2_src_q) - SUM_W'(f2_relax_q) - SUM_W'(f2_spg_q);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      f1_vld_q    <= 1'b0;
      f2_vld_q    <= 1'b0;
      out_valid_q <= 1'b0;
    end else if (adv) begin
      f1_vld_q    <= vld_q[CARRY_N-1];
      f2_vld_q    <= f1_vld_q;
      out_valid_q <= f2_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      f1_relax_q <= relax_w;
      f1_tgt_q   <= sat_s32(SUM_W'(tgt_w));
      f1_s_q     <= c_q[CARRY_N-1].s;
      f1_temp_q  <= c_q[CARRY_N-1].temp;
      f1_src_q   <= c_q[CARRY_N-1].src;
      f2_relax_q <= f1_relax_q;
      f2_spg_q   <= spg_w;
      f2_src_q   <= f1_src_q;
      out_q      <= sat_s32(total);
    end
  end

  assign out_valid_o  = out_valid_q;
  assign source_out_o = out_q;

`ifndef NO_ASSERTIONS
  a_accept_enters : assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> p1_vld_q)
    else $error("accepted item missing from first stage");

  a_stall_holds : assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |=> $stable(vld_q) && $stable(p1_vld_q) && $stable(f2_vld_q))
    else $error("pipeline moved during stall");

  a_load_no_result : assert property (@(posedge clk_i) disable iff (!rst_ni)
    adv && p1_vld_q && (p1_op_q == OP_LOAD) |=> !vld_q[0])
    else $error("load item produced a result slot");

  a_last_to_out : assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_ready_o && f2_vld_q |=> out_valid_o)
    else $error("finished item lost before output");
`endif

endmodule

// ===== sim/temperature_relax_sponge_source_core_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// temperature_relax_sponge_source_core_tb
// Streams profile loads and cell items through the source core under random
// idling on both channels, predicts each source_out in-line and compares the
// results in order. Register settings change between drained phases.
// ----------------------------------------------------------------------------
module temperature_relax_sponge_source_core_tb;
  import trss_pkg::*;

  typedef struct packed {
    logic               op;
    logic [3:0]         idx;
    logic signed [31:0] hgt;
    logic signed [31:0] val;
    logic signed [31:0] x;
    logic signed [31:0] y;
    logic signed [31:0] z;
    logic [30:0]        half;
    logic signed [31:0] terr;
    logic               blank;
    logic signed [31:0] temp;
    logic signed [31:0] src;
  } item_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid_i = 1'b0;
  logic in_ready_o;
  item_t cur = '0;
  logic out_valid_o;
  logic out_ready_i = 1'b0;
  logic signed [31:0] source_out_o;
  logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [5:0] paddr = '0;
  logic [63:0] pwdata = '0;
  logic [63:0] prdata;
  logic pready;

  temperature_relax_sponge_source_core u_top (
    .clk_i, .rst_ni, .in_valid_i, .in_ready_o,
    .operation_i(cur.op), .entry_index_i(cur.idx), .entry_height_i(cur.hgt),
    .entry_value_i(cur.val), .cell_x_i(cur.x), .cell_y_i(cur.y),
    .cell_z_i(cur.z), .half_cell_height_i(cur.half),
    .terrain_height_i(cur.terr), .blanked_i(cur.blank),
    .temperature_i(cur.temp), .source_in_i(cur.src),
    .out_valid_o, .out_ready_i, .source_out_o,
    .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready
  );

  initial forever #1 clk_i = ~clk_i;

  item_t pending_items[$];
  logic signed [31:0] expected_source[$];
  int mismatches = 0;
  int cyc = 0;
  int stall_cnt = 0;

  // shadow of the core registers and profile table
  longint     m_start;
  bit [63:0]  m_invts, m_gain, m_west, m_east, m_south, m_north;
  int         m_count;
  longint     m_hgt[PROFILE_DEPTH];
  longint     m_val[PROFILE_DEPTH];

  function automatic bit [63:0] clip_u32(bit [63:0] v);
    return v > 64'hFFFF_FFFF ? 64'hFFFF_FFFF : v;
  endfunction

  function automatic longint clip_s32(longint v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

  function automatic longint qmul(longint a, bit [63:0] b);
    bit [63:0] mag;
    bit [63:0] p;
    mag = a < 0 ? -a : a;
    p = (mag * b) >> FRAC_BITS;
    return a < 0 ? -longint'(p) : longint'(p);
  endfunction

  function automatic longint profile_at(longint zq, int n);
    int j;
    longint h0, h1, v0, v1, dv;
    bit [63:0] dz, dh, q;
    if (zq <= m_hgt[0]) return m_val[0];
    if (zq >= m_hgt[n-1]) return m_val[n-1];
    for (j = 1; j + 1 < n; j++)
      if (m_hgt[j] > zq) break;
    h0 = m_hgt[j-1];
    h1 = m_hgt[j];
    v0 = m_val[j-1];
    v1 = m_val[j];
    dz = zq - h0;
    dh = h1 - h0;
    dv = v1 - v0;
    q = ((dv < 0 ? -dv : dv) * dz) / dh;
    return dv < 0 ? v0 - longint'(q) : v0 + longint'(q);
  endfunction

  function automatic bit [63:0] side_damp(longint c, bit [63:0] r, bit rising,
                                          bit [63:0] strength);
    longint st, d;
    bit [63:0] inv, xi, sq;
    st = longint'(signed'(r[63:32]));
    inv = r[31:0];
    d = rising ? c - st : st - c;
    if (inv == 0 || d <= 0) return 0;
    xi = clip_u32((64'(d) * inv) >> FRAC_BITS);
    sq = clip_u32((xi * xi) >> FRAC_BITS);
    return clip_u32((sq * strength) >> FRAC_BITS);
  endfunction

  function automatic void predict_source(item_t it);
    int n;
    longint temp, zq, ref_t, relax, sponge, ref2, target;
    bit [63:0] strength, s;
    if (it.op == OP_LOAD) begin
      m_hgt[it.idx] = it.hgt;
      m_val[it.idx] = it.val;
      return;
    end
    n = m_count > PROFILE_DEPTH ? PROFILE_DEPTH : m_count;
    temp = it.temp;
    relax = 0;
    if (!it.blank) begin
      zq = longint'(it.z) - longint'(it.terr);
      if (zq < longint'(it.half)) zq = longint'(it.half);
      ref_t = temp;
      if (zq > m_start && n > 0) ref_t = profile_at(zq, n);
      relax = qmul(temp - ref_t, m_invts);
    end
    sponge = 0;
    strength = m_gain[63:32];
    if (strength != 0) begin
      s = side_damp(it.x, m_west, 1'b0, strength) + side_damp(it.x, m_east, 1'b1, strength)
        + side_damp(it.y, m_south, 1'b0, strength) + side_damp(it.y, m_north, 1'b1, strength);
      ref2 = n > 0 ? profile_at(it.z, n) : temp;
      target = clip_s32(qmul(ref2, m_gain[31:0]));
      sponge = qmul(temp - target, clip_u32(s));
    end
    expected_source.push_back(clip_s32(longint'(it.src) - relax - sponge));
  endfunction

  function automatic void queue_item(item_t it);
    pending_items.push_back(it);
    predict_source(it);
  endfunction

  function automatic logic [31:0] rnd32();
    case ($urandom_range(7))
      0: return 32'h8000_0000;
      1: return 32'h7FFF_FFFF;
      2: return 32'h0;
      3: return 32'hFFFF_FFFF;
      default: return $urandom;
    endcase
  endfunction

  function automatic item_t rand_cell();
    item_t it;
    it = '0;
    it.op = OP_CELL;
    it.idx = 4'($urandom);
    it.hgt = $urandom;
    it.val = $urandom;
    if ($urandom_range(3) == 0) begin
      it.x = rnd32(); it.y = rnd32(); it.z = rnd32(); it.half = 31'(rnd32());
      it.terr = rnd32(); it.temp = rnd32(); it.src = rnd32();
    end else begin
      it.x = $urandom_range(32'h0400_0000);
      it.y = $urandom_range(32'h0400_0000);
      it.z = $urandom_range(32'h0800_0000) - 32'h0040_0000;
      it.half = 31'($urandom_range(32'h000A_0000));
      it.terr = $urandom_range(3) == 0 ? 32'h0 : $urandom_range(32'h0100_0000);
      it.temp = 32'h0118_0000 + $urandom_range(32'h0040_0000);
      it.src = $urandom_range(32'h0010_0000) - 32'h0008_0000;
    end
    it.blank = $urandom_range(4) == 0;
    return it;
  endfunction

  // sorted profile, heights rising from a random base
  function automatic void load_profile();
    item_t it;
    logic signed [31:0] h;
    h = $urandom_range(32'h0080_0000) - 32'h0020_0000;
    for (int i = 0; i < PROFILE_DEPTH; i++) begin
      it = rand_cell();
      it.op = OP_LOAD;
      it.idx = 4'(i);
      it.hgt = h;
      it.val = 32'h0118_0000 + $urandom_range(32'h0040_0000);
      h = h + 1 + $urandom_range(32'h0080_0000);
      queue_item(it);
    end
  endfunction

  task automatic reg_write(logic [2:0] idx, logic [63:0] v);
    @(posedge clk_i);
    psel <= 1'b1; pwrite <= 1'b1; paddr <= {idx, 3'b000}; pwdata <= v;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    case (idx)
      REG_START: m_start = longint'(signed'(v[31:0]));
      REG_INVTS: m_invts = v[30:0];
      REG_GAIN:  m_gain = v;
      REG_WEST:  m_west = v;
      REG_EAST:  m_east = v;
      REG_SOUTH: m_south = v;
      REG_NORTH: m_north = v;
      default:   m_count = v[4:0];
    endcase
  endtask

  task automatic drain();
    while (pending_items.size() != 0 || expected_source.size() != 0) @(posedge clk_i);
    repeat (30) @(posedge clk_i);
  endtask

  task automatic write_all(logic [63:0] st, logic [63:0] it, logic [63:0] g,
                           logic [63:0] w, logic [63:0] e, logic [63:0] s,
                           logic [63:0] nn, logic [63:0] c);
    reg_write(REG_START, st); reg_write(REG_INVTS, it); reg_write(REG_GAIN, g);
    reg_write(REG_WEST, w); reg_write(REG_EAST, e); reg_write(REG_SOUTH, s);
    reg_write(REG_NORTH, nn); reg_write(REG_COUNT, c);
  endtask

  function automatic logic [63:0] side_rand();
    logic [63:0] v;
    v[63:32] = $urandom_range(32'h0400_0000);
    v[31:0] = $urandom_range(2) == 0 ? 32'h0 : $urandom_range(32'h0000_4000);
    if ($urandom_range(9) == 0) v = {$urandom, $urandom};
    return v;
  endfunction

  initial begin
    item_t it;
    m_start = 0; m_invts = 0; m_gain = 0; m_west = 0; m_east = 0;
    m_south = 0; m_north = 0; m_count = 0;
    for (int i = 0; i < PROFILE_DEPTH; i++) begin
      m_hgt[i] = 0; m_val[i] = 0;
    end
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;

    // reset settings: empty profile, loads of extreme entries, cells pass through
    for (int i = 0; i < PROFILE_DEPTH; i++) begin
      it = rand_cell();
      it.op = OP_LOAD;
      it.idx = 4'(15 - i);
      it.hgt = (15 - i) == 0 ? 32'sh8000_0000 : (15 - i) == 15 ? 32'sh7FFF_FFFF
             : (15 - i) * 32'sh0100_0000 - 32'sh0800_0000;
      it.val = i[0] ? 32'sh7FFF_FFFF : 32'sh8000_0000;
      queue_item(it);
    end
    for (int i = 0; i < 4; i++) begin
      it = rand_cell();
      it.src = i[0] ? 32'sh7FFF_FFFF : 32'sh8000_0000;
      it.blank = i[1];
      queue_item(it);
    end
    drain();

    // extremes: start at its most negative, every other register at its top, count beyond the table
    write_all(64'h8000_0000, 64'h7FFF_FFFF, '1, '1, '1, '1, '1, 64'd31);
    for (int i = 0; i < 6; i++) begin
      it = rand_cell();
      it.x = i[0] ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
      it.y = i[1] ? 32'sh7FFF_FFFF : 32'sh8000_0000;
      it.z = i[0] ? 32'sh7FFF_FFFF : 32'sh8000_0000;
      it.terr = i[1] ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
      it.half = i[2] ? '1 : '0;
      it.temp = i[0] ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
      it.src = i[1] ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
      it.blank = i == 5;
      queue_item(it);
    end
    drain();

    for (int ph = 0; ph < 5; ph++) begin
      if (ph == 4)
        write_all(64'h7FFF_FFFF, 64'h0, 64'h0, 64'h0, 64'h0, 64'h0, 64'h0, 64'd1);
      else
        write_all($urandom_range(32'h0080_0000), $urandom_range(32'h0000_2000),
                  {$urandom_range(1) ? 32'h0 : $urandom_range(32'h0002_0000),
                   $urandom_range(32'h0002_0000)},
                  side_rand(), side_rand(), side_rand(), side_rand(),
                  $urandom_range(31));
      load_profile();
      for (int k = 0; k < 60; k++) begin
        case ($urandom_range(19))
          0, 1: begin
            it = rand_cell();
            it.op = OP_LOAD;
            it.hgt = rnd32();
            it.val = rnd32();
            queue_item(it);
          end
          2: load_profile();
          default: queue_item(rand_cell());
        endcase
      end
      drain();
    end

    if (mismatches == 0 && expected_source.size() == 0) $display("Simulation PASSED");
    else $display("Simulation FAILED");
    $finish;
  end

  // quiet window with no idling on either side
  function automatic bit no_idle();
    return (cyc % 4000) >= 1500 && (cyc % 4000) < 2500;
  endfunction

  always @(posedge clk_i) begin
    cyc <= cyc + 1;
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
      out_ready_i <= 1'b0;
    end else begin
      out_ready_i <= no_idle() || $urandom_range(99) >= 27;
      if (!in_valid_i || in_ready_o) begin
        if (in_valid_i) void'(pending_items.pop_front());
        if (pending_items.size() != 0 && (no_idle() || $urandom_range(99) >= 27)) begin
          in_valid_i <= 1'b1;
          cur <= pending_items[0];
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (expected_source.size() == 0) begin
        mismatches <= mismatches + 1;
        if (mismatches < 10) $display("unexpected item: source_out %0d", source_out_o);
      end else begin
        if (source_out_o !== expected_source[0]) begin
          mismatches <= mismatches + 1;
          if (mismatches < 10)
            $display("source_out mismatch: expected %0d got %0d",
                     expected_source[0], source_out_o);
        end
        void'(expected_source.pop_front());
      end
    end
  end

  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i) || psel || !rst_ni)
      stall_cnt <= 0;
    else if (stall_cnt >= 5000) begin
      $display("Simulation FAILED");
      $finish;
    end else
      stall_cnt <= stall_cnt + 1;
  end

endmodule
